>>> rtl/xts_pkg.sv
// shared widths, matrix coefficients and pipeline control types for the xyz to srgb converter
package xts_pkg;

  // field widths
  localparam int IN_W   = 16;
  localparam int CODE_W = 12;

  // matrix datapath widths: Q16 coefficients times Q14 components give Q30
  localparam int COEF_W = 19;
  localparam int PROD_W = 36;
  localparam int LIN_W  = 38;

  // pipeline depth: two matrix stages, six encode stages
  localparam int MAT_STAGES = 2;
  localparam int ENC_STAGES = 6;
  localparam int NSTAGE     = MAT_STAGES + ENC_STAGES;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [LIN_W-1:0]  lin_t;

  // xyz to linear srgb, row major, signed Q16
  localparam coef_t COEF [9] = '{
     19'sd212400, -19'sd100754,  -19'sd32677,
     -19'sd63520,  19'sd122943,    19'sd2723,
       19'sd3646,  -19'sd13368,   19'sd69270
  };

  // which part of the transfer curve a linear value falls in
  typedef enum logic [1:0] {
    SEG_ZERO   = 2'd0,
    SEG_FULL   = 2'd1,
    SEG_LINEAR = 2'd2,
    SEG_CURVE  = 2'd3
  } seg_t;

  // per-stage load enables, stage 0 nearest the input
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } xts_ctl_t;

endpackage

>>> rtl/xts_matrix.sv
// 3x3 matrix multiply: products in the first stage, row sums in the second
module xts_matrix
  import xts_pkg::*;
(
  input  logic            clk,
  input  xts_ctl_t        ctl,
  input  logic [IN_W-1:0] x_value,
  input  logic [IN_W-1:0] y_value,
  input  logic [IN_W-1:0] z_value,
  output lin_t            lin [3]
);

  logic [IN_W-1:0] comp [3];
  prod_t prod_nxt [9];
  prod_t prod_r   [9];
  lin_t  lin_nxt  [3];
  lin_t  lin_r    [3];

  assign comp[0] = x_value;
  assign comp[1] = y_value;
  assign comp[2] = z_value;

  // nine coefficient products, inputs taken as unsigned
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[3*r+c] = PROD_W'(COEF[3*r+c]) * PROD_W'(signed'({1'b0, comp[c]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      prod_r <= prod_nxt;
    end
  end

  // row sums give signed Q30 linear values
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lin_nxt[r] = lin_t'(prod_r[3*r]) + lin_t'(prod_r[3*r+1]) + lin_t'(prod_r[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      lin_r <= lin_nxt;
    end
  end

  assign lin = lin_r;

endmodule

>>> rtl/xts_encode.sv
// srgb transfer curve for one channel: segment select, table lookup, interpolation, clamp
module xts_encode
  import xts_pkg::*;
#(
  parameter int GAMMA_ENTRIES = 1024
) (
  input  logic              clk,
  input  xts_ctl_t          ctl,
  input  lin_t              lin,
  output logic [CODE_W-1:0] code
);

  localparam int FRAC_W   = 30;
  localparam int IDX_W    = $clog2(GAMMA_ENTRIES + 1);
  localparam int P_W      = FRAC_W + IDX_W;
  localparam int LSEG_W   = 22;
  localparam int LP_W     = 54;
  localparam int LCODE_W  = 8;
  localparam int GAMMA_W  = 22;
  localparam int DP_W     = GAMMA_W + FRAC_W;
  localparam int V_W      = GAMMA_W + 1;
  localparam int SC_W     = 36;
  localparam int S0       = MAT_STAGES;

  localparam lin_t ONE_Q30    = lin_t'(1073741824);
  localparam lin_t THRESH_Q30 = lin_t'(3361671);
  // 12.92 in Q16 times 4095
  localparam logic [31:0]     LIN_SCALE  = 32'd3467338875;
  localparam logic [LP_W-1:0] LIN_ROUND  = LP_W'(64'd1 << 45);
  localparam logic [SC_W-1:0] CODE_SCALE = SC_W'(4095);
  localparam logic [SC_W-1:0] ROUND_Q20  = SC_W'(64'd1 << 19);
  localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(GAMMA_ENTRIES - 1);
  localparam logic [63:0] SCALE_Q20  = 64'd1106248;
  localparam logic [63:0] OFFSET_Q20 = 64'd57672;

  typedef logic signed [GAMMA_W-1:0] gtab_t [GAMMA_ENTRIES+1];

  // floor square root, two bits of the radicand per step
  function automatic logic [63:0] isqrt(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = xin;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor cube root, three bits of the radicand per step
  function automatic logic [63:0] icbrt(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] b;
    int          s;
    x = xin;
    y = '0;
    for (int i = 0; i < 22; i++) begin
      s = 63 - 3 * i;
      y = y << 1;
      b = 64'd3 * y * (y + 64'd1) + 64'd1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 64'd1;
      end
    end
    return y;
  endfunction

  // Q20 samples of 1.055*u^(5/12)-0.055, u^(5/12) as cbrt(u * u^(1/4))
  function automatic gtab_t build_gtab();
    gtab_t       tab;
    logic [63:0] t;
    logic [63:0] sq;
    logic [63:0] qr;
    logic [63:0] w;
    logic [63:0] r;
    logic [63:0] rv;
    for (int k = 0; k <= GAMMA_ENTRIES; k++) begin
      t  = (64'(k) << 30) / GAMMA_ENTRIES;
      sq = isqrt(t << 30);
      qr = isqrt(sq << 30);
      w  = (t * qr) >> 30;
      r  = icbrt(w << 33);
      rv = (r * SCALE_Q20 + (64'd1 << 20)) >> 21;
      tab[k] = GAMMA_W'(rv - OFFSET_Q20);
    end
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

  // stage a: segment, table position, linear segment product
  seg_t              seg_a_nxt;
  seg_t              seg_a_r;
  logic [P_W-1:0]    pos_a_r;
  logic [LP_W-1:0]   lp_a_r;

  always_comb begin
    if (lin <= lin_t'(0)) begin
      seg_a_nxt = SEG_ZERO;
    end else if (lin >= ONE_Q30) begin
      seg_a_nxt = SEG_FULL;
    end else if (lin <= THRESH_Q30) begin
      seg_a_nxt = SEG_LINEAR;
    end else begin
      seg_a_nxt = SEG_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0]) begin
      seg_a_r <= seg_a_nxt;
      pos_a_r <= P_W'(lin[FRAC_W-1:0]) * P_W'(GAMMA_ENTRIES);
      lp_a_r  <= LP_W'(lin[LSEG_W-1:0]) * LP_W'(LIN_SCALE);
    end
  end

  // stage b: table read at both ends of the interval, linear code rounded
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_c;
  logic [LP_W-1:0]           lround;
  logic signed [GAMMA_W-1:0] t0_b_r;
  logic signed [GAMMA_W-1:0] t1_b_r;
  logic [FRAC_W-1:0]         frac_b_r;
  seg_t                      seg_b_r;
  logic [LCODE_W-1:0]        lcode_b_r;

  assign idx    = pos_a_r[P_W-1:FRAC_W];
  assign idx_c  = (idx > LAST_IDX) ? LAST_IDX : idx;
  assign lround = lp_a_r + LIN_ROUND;

  always_ff @(posedge clk) begin
    if (ctl.en[S0+1]) begin
      t0_b_r    <= GTAB[idx_c];
      t1_b_r    <= GTAB[IDX_W'(idx_c + 1'b1)];
      frac_b_r  <= pos_a_r[FRAC_W-1:0];
      seg_b_r   <= seg_a_r;
      lcode_b_r <= lround[LP_W-1:LP_W-LCODE_W];
    end
  end

  // stage c: slope, flat or falling counts as zero
  logic [GAMMA_W-1:0]        diff_c_r;
  logic signed [GAMMA_W-1:0] t0_c_r;
  logic [FRAC_W-1:0]         frac_c_r;
  seg_t                      seg_c_r;
  logic [LCODE_W-1:0]        lcode_c_r;

  always_ff @(posedge clk) begin
    if (ctl.en[S0+2]) begin
      diff_c_r  <= (t1_b_r > t0_b_r) ? GAMMA_W'(t1_b_r - t0_b_r) : '0;
      t0_c_r    <= t0_b_r;
      frac_c_r  <= frac_b_r;
      seg_c_r   <= seg_b_r;
      lcode_c_r <= lcode_b_r;
    end
  end

  // stage d: slope times fraction
  logic [DP_W-1:0]           dp_d_r;
  logic signed [GAMMA_W-1:0] t0_d_r;
  seg_t                      seg_d_r;
  logic [LCODE_W-1:0]        lcode_d_r;

  always_ff @(posedge clk) begin
    if (ctl.en[S0+3]) begin
      dp_d_r    <= DP_W'(diff_c_r) * DP_W'(frac_c_r);
      t0_d_r    <= t0_c_r;
      seg_d_r   <= seg_c_r;
      lcode_d_r <= lcode_c_r;
    end
  end

  // stage e: interpolated curve value in Q20
  logic signed [V_W-1:0] v_e_r;
  seg_t                  seg_e_r;
  logic [LCODE_W-1:0]    lcode_e_r;

  always_ff @(posedge clk) begin
    if (ctl.en[S0+4]) begin
      v_e_r     <= V_W'(t0_d_r) + signed'({1'b0, dp_d_r[DP_W-1:FRAC_W]});
      seg_e_r   <= seg_d_r;
      lcode_e_r <= lcode_d_r;
    end
  end

  // stage f: scale to 12-bit code, clamp and pick by segment
  logic [SC_W-1:0]   sc;
  logic [SC_W-21:0]  ccode;
  logic [CODE_W-1:0] curve_code;
  logic [CODE_W-1:0] code_nxt;
  logic [CODE_W-1:0] code_r;

  assign sc    = SC_W'(v_e_r[V_W-2:0]) * CODE_SCALE + ROUND_Q20;
  assign ccode = sc[SC_W-1:20];

  always_comb begin
    if (v_e_r <= V_W'(0)) begin
      curve_code = '0;
    end else if (ccode > (SC_W-20)'(CODE_MAX)) begin
      curve_code = CODE_MAX;
    end else begin
      curve_code = ccode[CODE_W-1:0];
    end
  end

  always_comb begin
    case (seg_e_r)
      SEG_ZERO:   code_nxt = '0;
      SEG_FULL:   code_nxt = CODE_MAX;
      SEG_LINEAR: code_nxt = CODE_W'(lcode_e_r);
      SEG_CURVE:  code_nxt = curve_code;
      default:    code_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[S0+5]) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule

>>> rtl/xyz_to_srgb_converter.sv
// top level: cie xyz pixel stream in, gamma-encoded srgb pixel stream out
//
//   channel   direction   payload (low bit first)                 handshake
//   in_       slave       x_value, y_value, z_value (48 bits)      tvalid/tready
//   out_      master      red, green, blue, 4 zero bits (40 bits)  tvalid/tready
//
// one pixel per clock sustained while out_tready stays high; each pixel
// passes through the stage registers in order: two matrix stages, then
// table position, table read, slope, product, interpolation and code scaling
// reset clears only the stage valid bits, payload registers are left as they are
// a stalled output holds its result; empty stages behind it keep filling, so
// in_tready drops only once every stage holds a pixel
module xyz_to_srgb_converter
  import xts_pkg::*;
#(
  parameter int GAMMA_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_value[15:0], y_value[31:16], z_value[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // red[11:0], green[23:12], blue[35:24], zero[39:36]
);

  xts_ctl_t          ctl;
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  lin_t              lin [3];
  logic [CODE_W-1:0] code [3];

  // stage enables: a stage loads when it is empty or the next one loads
  always_comb begin
    ctl.en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      ctl.en[i] = !vld_r[i] || ctl.en[i+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    vld_nxt = vld_r;
    if (ctl.en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (ctl.en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = ctl.en[0];
  assign out_tvalid = vld_r[NSTAGE-1];

  // matrix multiply
  xts_matrix u_matrix (
    .clk     (clk),
    .ctl     (ctl),
    .x_value (in_tdata[15:0]),
    .y_value (in_tdata[31:16]),
    .z_value (in_tdata[47:32]),
    .lin     (lin)
  );

  // one transfer curve per channel
  for (genvar ch = 0; ch < 3; ch++) begin : g_enc
    xts_encode #(
      .GAMMA_ENTRIES (GAMMA_ENTRIES)
    ) u_encode (
      .clk  (clk),
      .ctl  (ctl),
      .lin  (lin[ch]),
      .code (code[ch])
    );
  end

  assign out_tdata = {4'b0000, code[2], code[1], code[0]};

endmodule

>>> rtl/xts_checker.sv
// port-level checks on the xyz to srgb converter, bound to the top level
module xts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a request not taken stays, unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("waiting request changed or dropped");

  // a result not taken stays, unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // with the output empty the pipeline has room, so requests are taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // padding bits above the blue code stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'b0000)
    else $error("nonzero padding in result");

endmodule

bind xyz_to_srgb_converter xts_checker u_xts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/xts_srgb_checker.sv
// checker for the xyz to srgb converter: predicts each pixel and compares the results
module xts_srgb_checker #(
  parameter int GAMMA_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // x_value[15:0], y_value[31:16], z_value[47:32]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // red[11:0], green[23:12], blue[35:24], zero[39:36]
  output int          results_pending,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // xyz to linear srgb, row major, signed Q16
  localparam longint MATRIX_Q16 [9] = '{
     212400, -100754,  -32677,
     -63520,  122943,    2723,
       3646,  -13368,   69270
  };

  localparam longint ONE_Q30    = 64'sd1 << 30;
  localparam longint KNEE_Q30   = 3361671;
  localparam int     REPORT_CAP = 100;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } srgb_px_t;

  // transfer curve samples, signed Q20
  int gamma_lut [0:GAMMA_ENTRIES];

  srgb_px_t srgb_expected [$];
  int       errs;

  // floor square root
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = v;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor cube root, three bits of radicand per step
  function automatic logic [63:0] icbrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] b;
    x = v;
    y = 64'd0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 64'd3 * y * (y + 64'd1) + 64'd1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 64'd1;
      end
    end
    return y;
  endfunction

  // 1.055 * u^(5/12) - 0.055 at u = k / entries, u^(5/12) = cbrt(u * u^(1/4))
  task automatic build_gamma_lut();
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] w;
    logic [63:0] r;
    logic [63:0] scaled;
    logic [63:0] kk;
    for (int k = 0; k <= GAMMA_ENTRIES; k++) begin
      kk     = 64'(k);
      t      = (kk << 30) / GAMMA_ENTRIES;
      s      = isqrt64(t << 30);
      q      = isqrt64(s << 30);
      w      = (t * q) >> 30;
      r      = icbrt64(w << 33);
      scaled = (r * 64'd1106248 + (64'd1 << 20)) >> 21;
      gamma_lut[k] = int'(scaled) - 57672;
    end
  endtask

  // linear Q30 value to 12-bit gamma code
  function automatic logic [11:0] encode_channel(input longint lin);
    logic [63:0] ul;
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] d;
    logic [63:0] c;
    longint      t0;
    longint      t1;
    longint      v;
    if (lin <= 0) return 12'd0;
    if (lin >= ONE_Q30) return 12'd4095;
    ul = lin;
    // linear segment near black
    if (lin <= KNEE_Q30) begin
      p = ul * 64'd846725 * 64'd4095;
      c = (p + (64'd1 << 45)) >> 46;
      return c[11:0];
    end
    // table position and interpolation
    p = ul * GAMMA_ENTRIES;
    k = p >> 30;
    f = p & ((64'd1 << 30) - 64'd1);
    if (k >= GAMMA_ENTRIES) k = 64'(GAMMA_ENTRIES - 1);
    t0 = gamma_lut[k];
    t1 = gamma_lut[k + 1];
    v  = t0;
    if (t1 > t0) begin
      d = t1 - t0;
      v = v + longint'((d * f) >> 30);
    end
    if (v <= 0) return 12'd0;
    c = (64'(v) * 64'd4095 + (64'd1 << 19)) >> 20;
    return (c > 64'd4095) ? 12'd4095 : c[11:0];
  endfunction

  function automatic srgb_px_t predict_pixel(input logic [47:0] d);
    longint   xyz [3];
    longint   lin;
    srgb_px_t px;
    logic [11:0] code [3];
    xyz[0] = longint'(d[15:0]);
    xyz[1] = longint'(d[31:16]);
    xyz[2] = longint'(d[47:32]);
    for (int i = 0; i < 3; i++) begin
      lin = MATRIX_Q16[3*i] * xyz[0] + MATRIX_Q16[3*i+1] * xyz[1]
          + MATRIX_Q16[3*i+2] * xyz[2];
      code[i] = encode_channel(lin);
    end
    px.red   = code[0];
    px.green = code[1];
    px.blue  = code[2];
    return px;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    errs++;
    if (errs <= REPORT_CAP)
      $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  initial begin
    errs = 0;
    build_gamma_lut();
  end

  // track requests and compare results in order
  always @(posedge clk) begin : monitor
    srgb_px_t want;
    int       depth;
    if (!rst_n) begin
      results_pending <= 0;
    end else begin
      depth = srgb_expected.size();
      if (out_tvalid && out_tready) begin
        if (depth == 0) begin
          errs++;
          if (errs <= REPORT_CAP)
            $display("%0d ns: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          want  = srgb_expected.pop_front();
          depth = depth - 1;
          if (out_tdata[11:0] !== want.red)
            flag_mismatch("red", int'(want.red), int'(out_tdata[11:0]));
          if (out_tdata[23:12] !== want.green)
            flag_mismatch("green", int'(want.green), int'(out_tdata[23:12]));
          if (out_tdata[35:24] !== want.blue)
            flag_mismatch("blue", int'(want.blue), int'(out_tdata[35:24]));
          if (out_tdata[39:36] !== 4'd0)
            flag_mismatch("pad", 0, int'(out_tdata[39:36]));
        end
      end
      if (in_tvalid && in_tready) begin
        srgb_expected.insert(srgb_expected.size(), predict_pixel(in_tdata));
        depth = depth + 1;
      end
      results_pending <= depth;
    end
    mismatch_count <= errs;
  end

endmodule

>>> tb/tb_xyz_to_srgb_converter.sv
// testbench top for the xyz to srgb converter: pixel stimulus, result pacing and verdict
module tb_xyz_to_srgb_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PIXELS = 1950;
  localparam int LONG_HOLD  = 80;
  localparam int NUM_DIRECT = 22;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // x_value[15:0], y_value[31:16], z_value[47:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // red[11:0], green[23:12], blue[35:24], zero[39:36]

  int results_pending;
  int mismatch_count;
  int results_taken;

  // directed pixels, packed as {z, y, x}
  logic [47:0] directed [NUM_DIRECT] = '{
    {16'd0,     16'd0,     16'd0},      // black
    {16'd65535, 16'd65535, 16'd65535},  // all components at max
    {16'd0,     16'd0,     16'd65535},  // x alone at max
    {16'd0,     16'd65535, 16'd0},      // y alone at max
    {16'd65535, 16'd0,     16'd0},      // z alone at max
    {16'd17843, 16'd16384, 16'd15573},  // d65 white
    {16'd0,     16'd16384, 16'd0},      // pure y, red goes negative
    {16'd0,     16'd0,     16'd8000},   // pure x, green goes negative
    {16'd1,     16'd1,     16'd1},      // smallest nonzero
    {16'd0,     16'd0,     16'd1},
    {16'd0,     16'd0,     16'd15},     // red just below the knee
    {16'd0,     16'd0,     16'd16},     // red just above the knee
    {16'd0,     16'd27,    16'd0},      // green around the knee
    {16'd0,     16'd28,    16'd0},
    {16'd48,    16'd0,     16'd0},      // blue around the knee
    {16'd49,    16'd0,     16'd0},
    {16'd0,     16'd0,     16'd5055},   // red just under one
    {16'd0,     16'd0,     16'd5056},   // red just over one
    {16'd0,     16'd8733,  16'd0},      // green just under one
    {16'd0,     16'd8734,  16'd0},      // green just over one
    {16'd3569,  16'd3277,  16'd3115},   // mid grey
    {16'd8192,  16'd8192,  16'd8192}
  };

  xyz_to_srgb_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  xts_srgb_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .results_pending (results_pending),
    .mismatch_count  (mismatch_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random pixel, mostly inside the usual xyz range
  function automatic logic [47:0] random_pixel();
    logic [15:0] c [3];
    int          pick;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (pick < 55)
        c[i] = 16'($urandom_range(0, 20000));
      else if (pick < 70)
        c[i] = 16'($urandom);
      else if (pick < 85)
        c[i] = 16'($urandom_range(0, 400));
      else if (pick < 92)
        c[i] = 16'd0;
      else
        case ($urandom_range(0, 2))
          0: c[i] = 16'd0;
          1: c[i] = 16'hffff;
          default: c[i] = 16'($urandom);
        endcase
    end
    // a single live component
    if (pick >= 85 && pick < 92)
      c[2'($urandom_range(0, 2))] = 16'($urandom);
    return {c[2], c[1], c[0]};
  endfunction

  // one request: idle gap, then hold until accepted
  task automatic send_pixel(input logic [47:0] px, input int gap);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  // sender
  initial begin
    int gap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int n = 0; n < NUM_PIXELS; n++) begin
      // back-to-back stretches, one of them overlapping the long output hold
      if ((n >= 170 && n < 520) || (n >= 700 && n < 900))
        gap = 0;
      else
        gap = $urandom_range(0, 5);
      // let the pipeline run dry once
      if (n == 1000) begin
        @(negedge clk) in_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
      end
      if (n < NUM_DIRECT)
        send_pixel(directed[n], gap);
      else
        send_pixel(random_pixel(), gap);
    end
    @(negedge clk) in_tvalid <= 1'b0;

    // drain, then let the pipeline settle before the verdict
    while (results_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver
  initial begin
    int stall;
    out_tready    = 1'b0;
    results_taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_taken == 200)
        stall = LONG_HOLD;
      else if (results_taken >= 600 && results_taken < 800)
        stall = 0;
      else
        stall = $urandom_range(0, 5);
      repeat (stall) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/xts_pkg.sv
rtl/xts_matrix.sv
rtl/xts_encode.sv
rtl/xyz_to_srgb_converter.sv
rtl/xts_checker.sv
tb/xts_srgb_checker.sv
tb/tb_xyz_to_srgb_converter.sv
